/* hdl/lfucr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfucr_pkg
// Shared sizes and types of the LFU counter replacement unit.
// ----------------------------------------------------------------------------
package lfucr_pkg;

   localparam int WAYS       = 4;
   localparam int SETS       = 64;
   localparam int COUNT_BITS = 16;

   localparam int WAY_BITS      = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int SET_ADDR_BITS = (SETS > 1) ? $clog2(SETS) : 1;

   // item field widths
   localparam int SET_IDX_BITS = 6;
   localparam int WAY_IDX_BITS = 2;
   localparam int VICTIM_BITS  = 2;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // one memory row holds every way's counter of a set
   typedef logic [WAYS-1:0][COUNT_BITS-1:0] count_row_type;

   localparam int ROW_BITS = WAYS * COUNT_BITS;

endpackage

/* hdl/lfucr_victim_sel.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfucr_victim_sel
// Picks the way to evict from one set's counters: first zero counter from
// way 1 upward, else the smallest count with the lowest way winning ties.
// ----------------------------------------------------------------------------
module lfucr_victim_sel (
   input  lfucr_pkg::count_row_type               row,
   output logic [lfucr_pkg::VICTIM_BITS-1:0]       victim_way
);
   import lfucr_pkg::*;

   logic [COUNT_BITS-1:0] lowest;
   logic [WAY_BITS-1:0]   chosen;
   logic                  found;
   logic [31:0]           chosen_ext;

   always_comb begin
      lowest = row[0];
      chosen = '0;
      found  = 1'b0;
      for (int w = 1; w < WAYS; w++) begin
         if (!found) begin
            if (row[w] == '0) begin
               chosen = WAY_BITS'(w);
               found  = 1'b1;
            end else if (row[w] < lowest) begin
               lowest = row[w];
               chosen = WAY_BITS'(w);
            end
         end
      end
   end

   // field is narrower than the way index when there are many ways
   assign chosen_ext = 32'(chosen);
   assign victim_way = chosen_ext[VICTIM_BITS-1:0];

endmodule

/* hdl/lfu_counter_replacement_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_counter_replacement_unit
// LFU replacement policy: per-way saturating use counters, victim query.
// ----------------------------------------------------------------------------
// The counters of each set live in one row of a single-port-style memory
// (one row per set, all ways side by side). After reset the unit sweeps the
// memory once to zero every counter, one row per cycle; req_tready stays low
// during the sweep. For each item the row is read into a register on the
// accepting edge; in execution the unit computes the update or the victim
// and, once the result register is free, writes the row back (for an update
// with a valid set and way) and loads the result register. As the counter
// memory is read, then written, a new item is accepted only after the last
// has left execution. A held result still lets one more item in; that item
// waits in execution, with req_tready low, until the result register is free.
// ----------------------------------------------------------------------------
module lfu_counter_replacement_unit (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: set[5:0], way_index[7:6], line_valid[8], zero fill
   input  logic [15:0] req_tdata,
   // req_tuser: mode[0] (0 = update, 1 = victim query)
   input  logic [0:0]  req_tuser,
   input  logic        req_tvalid,
   output logic        req_tready,
   // rsp_tdata: victim_way[1:0], zero fill
   output logic [7:0]  rsp_tdata,
   // rsp_tuser: victim_present[0]
   output logic [0:0]  rsp_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready
);
   import lfucr_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [SET_ADDR_BITS-1:0] clr_addr_ff, clr_addr_in;

   // item held while it executes
   logic                     mode_ff, mode_in;
   logic                     set_ok_ff, set_ok_in;
   logic                     way_ok_ff, way_ok_in;
   logic [WAY_BITS-1:0]      way_ff, way_in;
   logic                     line_valid_ff, line_valid_in;
   logic [SET_ADDR_BITS-1:0] addr_ff, addr_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VICTIM_BITS-1:0]   rsp_way_ff, rsp_way_in;
   logic                     rsp_present_ff, rsp_present_in;

   // counter memory
   logic [ROW_BITS-1:0]      mem [SETS];
   logic [ROW_BITS-1:0]      rd_data_ff;
   logic                     mem_re;
   logic [SET_ADDR_BITS-1:0] rd_addr;
   logic                     mem_we;
   logic [SET_ADDR_BITS-1:0] wr_addr;
   logic [ROW_BITS-1:0]      wr_data;

   logic [SET_IDX_BITS-1:0]  req_set;
   logic [WAY_IDX_BITS-1:0]  req_way;
   logic [31:0]              req_set_ext;
   logic [31:0]              req_way_ext;
   logic                     req_accept;
   logic                     out_free;
   logic                     clr_last;

   count_row_type            cur_row;
   count_row_type            new_row;
   logic [VICTIM_BITS-1:0]   pick_way;

   assign req_set     = req_tdata[5:0];
   assign req_way     = req_tdata[7:6];
   assign req_set_ext = 32'(req_set);
   assign req_way_ext = 32'(req_way);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign clr_last   = (32'(clr_addr_ff) == SETS - 1);

   assign cur_row = count_row_type'(rd_data_ff);

   lfucr_victim_sel u_victim_sel (
      .row        (cur_row),
      .victim_way (pick_way)
   );

   always_comb begin
      new_row = cur_row;
      if (line_valid_ff) begin
         if (cur_row[way_ff] != COUNT_MAX) begin
            new_row[way_ff] = cur_row[way_ff] + 1'b1;
         end
      end else begin
         new_row[way_ff] = '0;
      end
   end

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      mode_in        = mode_ff;
      set_ok_in      = set_ok_ff;
      way_ok_in      = way_ok_ff;
      way_in         = way_ff;
      line_valid_in  = line_valid_ff;
      addr_in        = addr_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_way_in     = rsp_way_ff;
      rsp_present_in = rsp_present_ff;
      mem_re         = 1'b0;
      rd_addr        = req_set_ext[SET_ADDR_BITS-1:0];
      mem_we         = 1'b0;
      wr_addr        = addr_ff;
      wr_data        = ROW_BITS'(new_row);

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               mem_re        = 1'b1;
               mode_in       = req_tuser[0];
               set_ok_in     = (req_set_ext < SETS);
               way_ok_in     = (req_way_ext < WAYS);
               way_in        = req_way_ext[WAY_BITS-1:0];
               line_valid_in = req_tdata[8];
               addr_in       = req_set_ext[SET_ADDR_BITS-1:0];
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_present_in = mode_ff;
               rsp_way_in     = (mode_ff && set_ok_ff) ? pick_way : '0;
               mem_we         = !mode_ff && set_ok_ff && way_ok_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      set_ok_ff      <= set_ok_in;
      way_ok_ff      <= way_ok_in;
      way_ff         <= way_in;
      line_valid_ff  <= line_valid_in;
      addr_ff        <= addr_in;
      rsp_way_ff     <= rsp_way_in;
      rsp_present_ff <= rsp_present_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(8 - VICTIM_BITS){1'b0}}, rsp_way_ff};
   assign rsp_tuser  = rsp_present_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_update_way_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[1:0] == '0)
      else $error("update item result carries a nonzero victim way");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !mem_we)
      else $error("counter memory written with no item in flight");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_EXEC)
      else $error("accepted item did not enter execution");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_EXEC))
      else $error("result appeared without an executing item");

   a_no_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !rsp_tvalid && !req_tready)
      else $error("traffic during the counter clearing sweep");

   a_exec_read_stable: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC && $past(state_ff == ST_EXEC) |-> $stable(rd_data_ff))
      else $error("row data changed while its item was stalled");

endmodule
